// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define STI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define STI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication, live through reset
`define STI_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/sti_pkg.sv =====
// constants, codes and types for the sorted insertion table
// no dependencies
package sti_pkg;

   localparam int CAPACITY   = 64;
   localparam int DataWidth  = 32;
   localparam int IndexWidth = 8;
   localparam int CountWidth = $clog2(CAPACITY + 1);
   localparam int CmpWidth   = (CountWidth > IndexWidth) ? CountWidth : IndexWidth;

   typedef enum logic [1:0] {
      OpInsert = 2'd0,
      OpRemove = 2'd1,
      OpRead   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      StOk    = 2'd0,
      StRange = 2'd1,
      StFull  = 2'd2
   } status_type;

   typedef struct packed {
      logic do_insert;
      logic do_remove;
      logic occupied;
      logic after_idx;
   } cell_ctrl_type;

endpackage

// ===== rtl/sorted_table_insert_remove.sv =====
// top level of the sorted insertion table: request decode, cell row,
// entry count and result register; uses sti_pkg and sti_cell
//
// The table keeps up to 64 signed 32-bit values in ascending order in a
// row of cells, each of which compares its entry with the request in
// parallel and shifts one place toward or away from its neighbor. A
// request is taken every cycle while the result register is free or
// being emptied; its result appears in the next cycle and carries the
// entry count after the request and a status. Throughput is one request
// per cycle while the result register is free or being emptied.
// Inserts place the value after any equal entries; an insert into a
// full table is dropped with status full; a remove or read at an index
// at or beyond the count changes nothing and reports out of range. The
// table is empty after reset, with no clearing pass.
module sorted_table_insert_remove (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // op[1:0], value[33:2], index[41:34], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // read_value[31:0], entry_count[38:32], status[40:39], zero pad
);

   localparam int Cap = sti_pkg::CAPACITY;
   localparam int DW  = sti_pkg::DataWidth;
   localparam int CW  = sti_pkg::CountWidth;
   localparam int MW  = sti_pkg::CmpWidth;

   logic                              accept;
   logic [1:0]                        req_op;
   logic signed [DW-1:0]              req_value;
   logic [sti_pkg::IndexWidth-1:0]    req_index;
   logic [MW-1:0]                     idx_ext;
   logic [MW-1:0]                     count_ext;
   logic                              full;
   logic                              in_range;
   logic                              ins_ok;
   logic                              rem_ok;

   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     count_in;
   logic                              rsp_valid_ff;
   logic signed [DW-1:0]              rd_value_ff;
   logic signed [DW-1:0]              rd_value_in;
   logic [CW-1:0]                     rsp_count_ff;
   sti_pkg::status_type               status_ff;
   sti_pkg::status_type               status_in;
   logic signed [DW-1:0]              sel_value;

   logic signed [DW-1:0]              cell_entry [Cap];
   logic                              cell_le    [Cap];
   sti_pkg::cell_ctrl_type            cell_ctrl  [Cap];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign req_op     = req_tdata[1:0];
   assign req_value  = req_tdata[33:2];
   assign req_index  = req_tdata[41:34];
   assign idx_ext    = MW'(req_index);
   assign count_ext  = MW'(count_ff);
   assign full       = (count_ff == CW'(Cap));
   assign in_range   = (idx_ext < count_ext);

   always_comb begin
      ins_ok      = 1'b0;
      rem_ok      = 1'b0;
      rd_value_in = '0;
      status_in   = sti_pkg::StOk;
      unique case (sti_pkg::op_type'(req_op))
         sti_pkg::OpInsert: begin
            if (full) status_in = sti_pkg::StFull;
            else      ins_ok    = 1'b1;
         end
         sti_pkg::OpRemove: begin
            if (in_range) rem_ok    = 1'b1;
            else          status_in = sti_pkg::StRange;
         end
         sti_pkg::OpRead: begin
            if (in_range) rd_value_in = sel_value;
            else          status_in   = sti_pkg::StRange;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok)      count_in = count_ff + CW'(1);
      else if (rem_ok) count_in = count_ff - CW'(1);
   end

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < Cap; i++) begin
         if (MW'(i) == idx_ext) sel_value = sel_value | cell_entry[i];
      end
   end

   for (genvar g = 0; g < Cap; g++) begin : g_cell
      assign cell_ctrl[g].do_insert = accept && ins_ok;
      assign cell_ctrl[g].do_remove = accept && rem_ok;
      assign cell_ctrl[g].occupied  = (MW'(g) < count_ext);
      assign cell_ctrl[g].after_idx = (MW'(g) >= idx_ext);

      if (g == 0) begin : g_first
         sti_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl[g]),
            .ins_value   (req_value),
            .left_entry  (req_value),
            .left_le     (1'b1),
            .right_entry (cell_entry[(g + 1) % Cap]),
            .entry       (cell_entry[g]),
            .le          (cell_le[g])
         );
      end else if (g == Cap - 1) begin : g_last
         sti_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl[g]),
            .ins_value   (req_value),
            .left_entry  (cell_entry[g - 1]),
            .left_le     (cell_le[g - 1]),
            .right_entry (cell_entry[g]),
            .entry       (cell_entry[g]),
            .le          (cell_le[g])
         );
      end else begin : g_mid
         sti_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl[g]),
            .ins_value   (req_value),
            .left_entry  (cell_entry[g - 1]),
            .left_le     (cell_le[g - 1]),
            .right_entry (cell_entry[g + 1]),
            .entry       (cell_entry[g]),
            .le          (cell_le[g])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) count_ff <= count_in;
         if (req_tready) rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_value_ff  <= rd_value_in;
         rsp_count_ff <= count_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, status_ff, 7'(rsp_count_ff), rd_value_ff};

endmodule

// ===== rtl/sti_cell.sv =====
// one slot of the sorted table: holds an entry, compares it with the
// inserted value and shifts to or from its neighbors; uses sti_pkg
module sti_cell (
   input  logic                                   clock,
   input  sti_pkg::cell_ctrl_type                 ctrl,
   input  logic signed [sti_pkg::DataWidth-1:0]   ins_value,
   input  logic signed [sti_pkg::DataWidth-1:0]   left_entry,
   input  logic                                   left_le,
   input  logic signed [sti_pkg::DataWidth-1:0]   right_entry,
   output logic signed [sti_pkg::DataWidth-1:0]   entry,
   output logic                                   le
);

   logic signed [sti_pkg::DataWidth-1:0] entry_ff;
   logic signed [sti_pkg::DataWidth-1:0] entry_in;

   assign le    = ctrl.occupied && (entry_ff <= ins_value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert && !le) begin
         entry_in = left_le ? ins_value : left_entry;
      end else if (ctrl.do_remove && ctrl.after_idx) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/sti_checker.sv =====
// port-level assertions for the sorted insertion table, bound to the top
// uses sti_pkg and assert_macros.svh
`include "assert_macros.svh"

module sti_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   `STI_ASSERT_RST(a_reset_idle, clock, reset, !rsp_tvalid)
   `STI_ASSERT_NXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `STI_ASSERT_IMP(a_full_count, clock, reset,
      rsp_tvalid && rsp_tdata[40:39] == sti_pkg::StFull,
      rsp_tdata[38:32] == 7'(sti_pkg::CAPACITY))
   `STI_ASSERT_IMP(a_range_zero, clock, reset,
      rsp_tvalid && rsp_tdata[40:39] != sti_pkg::StOk,
      rsp_tdata[31:0] == 32'd0 && (rsp_tdata[40:39] == sti_pkg::StRange
         || rsp_tdata[40:39] == sti_pkg::StFull))
   `STI_ASSERT_NXT(a_ready_free, clock, reset, !rsp_tvalid, req_tready || rsp_tvalid)

endmodule

bind sorted_table_insert_remove sti_checker u_sti_checker (.*);
